// ===== rtl/iol_pkg.sv =====
// Shared constants, codes and types for the indexed ordered list.
// No dependencies; every other file of the block takes its names from here.
package iol_pkg;

   // list geometry
   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // word field widths
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 4;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_APPEND   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_GET      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_INDEX_OF = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

   // request word
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] item_value;
   } req_type;

   // result word
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [FOUND_W-1:0]  found_position;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   // entry RAM write and read requests
   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      addr;
      logic [DATA_WIDTH-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

endpackage

// ===== rtl/iol_channels_if.sv =====
// Request and result channels of the indexed ordered list: valid, ready and payload.
// Depends on iol_pkg for the field widths.
interface iol_req_if;
   logic                           valid;
   logic                           ready;
   logic [iol_pkg::FUNC_W-1:0]     func;
   logic [iol_pkg::POS_W-1:0]      position;
   logic [iol_pkg::VALUE_W-1:0]    item_value;

   modport source (output valid, output func, output position, output item_value,
                   input ready);
   modport sink   (input valid, input func, input position, input item_value,
                   output ready);
endinterface

interface iol_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [iol_pkg::STATUS_W-1:0]   status;
   logic [iol_pkg::VALUE_W-1:0]    read_value;
   logic [iol_pkg::FOUND_W-1:0]    found_position;
   logic [iol_pkg::COUNT_W-1:0]    count;

   modport source (output valid, output status, output read_value,
                   output found_position, output count, input ready);
   modport sink   (input valid, input status, input read_value,
                   input found_position, input count, output ready);
endinterface

// ===== rtl/iol_ram.sv =====
// Entry store of the list: one write port and one read port, registered read data.
// Depends on iol_pkg for depth, width and the port request types.
module iol_ram (
   input  logic                           clock,
   input  iol_pkg::ram_wr_type            wr,
   input  iol_pkg::ram_rd_type            rd,
   output logic [iol_pkg::DATA_WIDTH-1:0] rd_data
);

   logic [iol_pkg::DATA_WIDTH-1:0] mem [iol_pkg::CAPACITY];
   logic [iol_pkg::DATA_WIDTH-1:0] rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read one entry into the registered read data
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/iol_seq.sv =====
// Sequencer of the list: checks a request against the count, walks the entry RAM
// one entry a cycle for shifts and searches, and hands the result word on.
// Depends on iol_pkg.
module iol_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  iol_pkg::req_type               req,
   input  logic                           out_free,
   output logic                           done,
   output iol_pkg::rsp_type               result,
   output iol_pkg::ram_wr_type            ram_wr,
   output iol_pkg::ram_rd_type            ram_rd,
   input  logic [iol_pkg::DATA_WIDTH-1:0] ram_rd_data
);

   typedef enum logic [3:0] {
      SEQ_IDLE = 4'b0001,
      SEQ_WALK = 4'b0010,
      SEQ_PUT  = 4'b0100,
      SEQ_DONE = 4'b1000
   } seq_state_type;

   seq_state_type                   state_ff, state_in;
   logic [iol_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            issuing_ff, issuing_in;
   logic                            pend_ff, pend_in;
   logic [iol_pkg::IDX_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [iol_pkg::IDX_W-1:0]       end_ff, end_in;
   logic [iol_pkg::IDX_W-1:0]       pend_addr_ff, pend_addr_in;
   logic [iol_pkg::IDX_W-1:0]       put_addr_ff, put_addr_in;
   logic                            down_ff, down_in;
   logic                            inc_ff, inc_in;
   logic                            dec_ff, dec_in;
   logic [iol_pkg::FUNC_W-1:0]      op_ff, op_in;
   logic [iol_pkg::IDX_W-1:0]       pos_ff, pos_in;
   logic [iol_pkg::DATA_WIDTH-1:0]  val_ff, val_in;
   logic [iol_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [iol_pkg::VALUE_W-1:0]     rd_val_ff, rd_val_in;
   logic [iol_pkg::FOUND_W-1:0]     found_ff, found_in;

   logic [iol_pkg::CNT_W-1:0]       cnt_less_one;
   logic [iol_pkg::CNT_W-1:0]       count_next;
   logic                            pos_past_end;
   logic                            is_full;

   assign cnt_less_one = count_ff - iol_pkg::CNT_W'(1);
   assign pos_past_end = iol_pkg::CNT_W'(req.position) >= count_ff;
   assign is_full      = count_ff == iol_pkg::CNT_W'(iol_pkg::CAPACITY);
   assign count_next   = count_ff + iol_pkg::CNT_W'(inc_ff) - iol_pkg::CNT_W'(dec_ff);

   assign req_ready = state_ff == SEQ_IDLE;

   // result word as it leaves the sequencer
   always_comb begin
      result.status         = status_ff;
      result.read_value     = rd_val_ff;
      result.found_position = found_ff;
      result.count          = iol_pkg::COUNT_W'(count_next);
   end

   // next state, RAM accesses and result fields
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issuing_in   = issuing_ff;
      pend_in      = pend_ff;
      rd_ptr_in    = rd_ptr_ff;
      end_in       = end_ff;
      pend_addr_in = pend_addr_ff;
      put_addr_in  = put_addr_ff;
      down_in      = down_ff;
      inc_in       = inc_ff;
      dec_in       = dec_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      rd_val_in    = rd_val_ff;
      found_in     = found_ff;
      ram_wr       = '0;
      ram_rd       = '0;
      done         = 1'b0;

      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               // take the request word and sort out the trivial answers
               op_in      = req.func;
               pos_in     = iol_pkg::IDX_W'(req.position);
               val_in     = iol_pkg::DATA_WIDTH'(req.item_value);
               status_in  = iol_pkg::STATUS_OK;
               rd_val_in  = '0;
               found_in   = '0;
               inc_in     = 1'b0;
               dec_in     = 1'b0;
               down_in    = 1'b0;
               issuing_in = 1'b0;
               pend_in    = 1'b0;
               state_in   = SEQ_DONE;
               case (req.func)
                  iol_pkg::FUNC_APPEND: begin
                     if (is_full) begin
                        status_in = iol_pkg::STATUS_FULL;
                     end else begin
                        put_addr_in = count_ff[iol_pkg::IDX_W-1:0];
                        inc_in      = 1'b1;
                        state_in    = SEQ_PUT;
                     end
                  end
                  iol_pkg::FUNC_INSERT: begin
                     if (pos_past_end) begin
                        status_in = iol_pkg::STATUS_RANGE;
                     end else if (is_full) begin
                        status_in = iol_pkg::STATUS_FULL;
                     end else begin
                        // move entries up, top first, then drop the value in
                        rd_ptr_in   = cnt_less_one[iol_pkg::IDX_W-1:0];
                        end_in      = iol_pkg::IDX_W'(req.position);
                        put_addr_in = iol_pkg::IDX_W'(req.position);
                        down_in     = 1'b1;
                        issuing_in  = 1'b1;
                        inc_in      = 1'b1;
                        state_in    = SEQ_WALK;
                     end
                  end
                  iol_pkg::FUNC_GET: begin
                     if (pos_past_end) begin
                        status_in = iol_pkg::STATUS_RANGE;
                     end else begin
                        rd_ptr_in  = iol_pkg::IDX_W'(req.position);
                        end_in     = iol_pkg::IDX_W'(req.position);
                        issuing_in = 1'b1;
                        state_in   = SEQ_WALK;
                     end
                  end
                  iol_pkg::FUNC_INDEX_OF: begin
                     // missing until a match turns up
                     status_in = iol_pkg::STATUS_MISSING;
                     if (count_ff != '0) begin
                        rd_ptr_in  = '0;
                        end_in     = cnt_less_one[iol_pkg::IDX_W-1:0];
                        issuing_in = 1'b1;
                        state_in   = SEQ_WALK;
                     end
                  end
                  iol_pkg::FUNC_REMOVE: begin
                     if (pos_past_end) begin
                        status_in = iol_pkg::STATUS_RANGE;
                     end else begin
                        rd_ptr_in  = iol_pkg::IDX_W'(req.position);
                        end_in     = cnt_less_one[iol_pkg::IDX_W-1:0];
                        issuing_in = 1'b1;
                        dec_in     = 1'b1;
                        state_in   = SEQ_WALK;
                     end
                  end
                  default: begin
                     status_in = iol_pkg::STATUS_OK;
                  end
               endcase
            end
         end

         SEQ_WALK: begin
            // issue the next read
            if (issuing_ff) begin
               ram_rd.en    = 1'b1;
               ram_rd.addr  = rd_ptr_ff;
               pend_in      = 1'b1;
               pend_addr_in = rd_ptr_ff;
               if (rd_ptr_ff == end_ff) begin
                  issuing_in = 1'b0;
               end else if (down_ff) begin
                  rd_ptr_in = rd_ptr_ff - iol_pkg::IDX_W'(1);
               end else begin
                  rd_ptr_in = rd_ptr_ff + iol_pkg::IDX_W'(1);
               end
            end else begin
               pend_in = 1'b0;
            end

            // use the word read last cycle; the write lands two entries
            // away from the read just issued, so the two never meet
            if (pend_ff) begin
               case (op_ff)
                  iol_pkg::FUNC_INSERT: begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = pend_addr_ff + iol_pkg::IDX_W'(1);
                     ram_wr.data = ram_rd_data;
                  end
                  iol_pkg::FUNC_REMOVE: begin
                     if (pend_addr_ff == pos_ff) begin
                        rd_val_in = iol_pkg::VALUE_W'(ram_rd_data);
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = pend_addr_ff - iol_pkg::IDX_W'(1);
                        ram_wr.data = ram_rd_data;
                     end
                  end
                  iol_pkg::FUNC_GET: begin
                     rd_val_in = iol_pkg::VALUE_W'(ram_rd_data);
                  end
                  iol_pkg::FUNC_INDEX_OF: begin
                     if (status_ff == iol_pkg::STATUS_MISSING && ram_rd_data == val_ff) begin
                        status_in = iol_pkg::STATUS_OK;
                        found_in  = iol_pkg::FOUND_W'(pend_addr_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // walk drained
            if (!issuing_ff && !pend_ff) begin
               state_in = (op_ff == iol_pkg::FUNC_INSERT) ? SEQ_PUT : SEQ_DONE;
            end
         end

         SEQ_PUT: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = put_addr_ff;
            ram_wr.data = val_ff;
            state_in    = SEQ_DONE;
         end

         SEQ_DONE: begin
            // hand the word over once the output register has room
            if (out_free) begin
               done     = 1'b1;
               count_in = count_next;
               state_in = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SEQ_IDLE;
         count_ff   <= '0;
         issuing_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         issuing_ff <= issuing_in;
         pend_ff    <= pend_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      end_ff       <= end_in;
      pend_addr_ff <= pend_addr_in;
      put_addr_ff  <= put_addr_in;
      down_ff      <= down_in;
      inc_ff       <= inc_in;
      dec_ff       <= dec_in;
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      status_ff    <= status_in;
      rd_val_ff    <= rd_val_in;
      found_ff     <= found_in;
   end

endmodule

// ===== rtl/indexed_ordered_list_core.sv =====
// Indexed ordered list: top level with the sequencer, the entry RAM and the result register.
// Depends on iol_pkg, iol_channels_if, iol_ram and iol_seq.

// A bounded list of up to 16 values of 32 bits in position order. Each request word
// carries an operation (append, insert, get, index_of, remove), a position and a
// value; each gives exactly one result word with status, value read, found position
// and the count after the operation. Requests are handled one at a time. The entries
// sit in a RAM with one read and one write port and registered read data, and
// shifts and searches walk it one entry a cycle. The number of entries read is 1 for
// get, count - position for insert (which then places the value in a separate step),
// count - position for remove and count for index_of on a list that is not empty;
// append only writes its value, and a request that is answered straight from the
// count (out of range, full, index_of on an empty list, unused code) touches no
// entry. The longest requests, index_of on a full list and remove at position 0 of
// a full list, read all 16 entries. The result sits in an output register, so a new
// request is taken while an earlier result waits; the block stalls only when a second
// result is ready before the first has gone.
module indexed_ordered_list_core (
   input  logic      clock,
   input  logic      reset,
   iol_req_if.sink   req_if,
   iol_rsp_if.source rsp_if
);

   iol_pkg::req_type               req_word;
   iol_pkg::rsp_type               result;
   iol_pkg::rsp_type               rsp_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;
   logic                           done;
   logic                           seq_ready;
   iol_pkg::ram_wr_type            ram_wr;
   iol_pkg::ram_rd_type            ram_rd;
   logic [iol_pkg::DATA_WIDTH-1:0] ram_rd_data;

   assign req_word.func       = req_if.func;
   assign req_word.position   = req_if.position;
   assign req_word.item_value = req_if.item_value;
   assign req_if.ready        = seq_ready;

   iol_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (seq_ready),
      .req         (req_word),
      .out_free    (out_free),
      .done        (done),
      .result      (result),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data)
   );

   iol_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   // hold the result word until the sink takes it
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_ff.status;
   assign rsp_if.read_value     = rsp_ff.read_value;
   assign rsp_if.found_position = rsp_ff.found_position;
   assign rsp_if.count          = rsp_ff.count;

   // one request at a time: no second word straight after an accepted one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while another is in progress");

   // a result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !done)
      else $error("result register overwritten while stalled");

   // a full answer comes only from a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == iol_pkg::STATUS_FULL)
      |-> (rsp_if.count == iol_pkg::COUNT_W'(iol_pkg::CAPACITY)))
      else $error("full status with a list that is not full");

   // no RAM write or read while the sequencer waits for a request
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !ram_wr.en && !ram_rd.en)
      else $error("entry RAM accessed while idle");

endmodule

// ===== test/tb_indexed_ordered_list_core.sv =====
// Self-checking bench for indexed_ordered_list_core: drives request words, predicts each result.
// Depends on iol_pkg, the iol_req_if and iol_rsp_if channels and the core itself.
// A scoreboard class keeps its own copy of the list and checks every result word.
module tb_indexed_ordered_list_core;
   timeunit 1ns;
   timeprecision 1ps;

   import iol_pkg::*;

   localparam int          HALF_PERIOD  = 6;
   localparam int          RESET_CYCLES = 7;
   localparam int          WORD_TARGET  = 700;
   localparam int          SETTLE_POINT = 350;
   localparam int          DRAIN_CYCLES = 25;
   localparam int          IDLE_LIMIT   = 1000;
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
   localparam logic [31:0] TWIN_VALUE   = 32'h0BAD_CAFE;

   // codes the block leaves unused
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   // Mirror of the list: predicts one result word per request word.
   class list_scoreboard;
      logic [DATA_WIDTH-1:0] entries [CAPACITY];
      int unsigned           list_count;
      rsp_type               awaited [$];
      int unsigned           mismatches;

      function new();
         list_count = 0;
         mismatches = 0;
      endfunction

      // Apply one accepted request to the mirror and queue its result.
      function void note_request(req_type w);
         rsp_type     r;
         int unsigned slot;
         int unsigned i;
         r        = '0;
         r.status = STATUS_OK;
         slot     = w.position;
         case (w.func)
            FUNC_APPEND: begin
               if (list_count >= CAPACITY) begin
                  r.status = STATUS_FULL;
               end else begin
                  entries[list_count] = w.item_value;
                  list_count++;
               end
            end
            FUNC_INSERT: begin
               if (slot >= list_count) begin
                  r.status = STATUS_RANGE;
               end else if (list_count >= CAPACITY) begin
                  r.status = STATUS_FULL;
               end else begin
                  for (i = list_count; i > slot; i--) entries[i] = entries[i-1];
                  entries[slot] = w.item_value;
                  list_count++;
               end
            end
            FUNC_GET: begin
               if (slot >= list_count) r.status = STATUS_RANGE;
               else r.read_value = entries[slot];
            end
            FUNC_INDEX_OF: begin
               r.status = STATUS_MISSING;
               for (i = 0; i < list_count; i++) begin
                  if (entries[i] == w.item_value) begin
                     r.status         = STATUS_OK;
                     r.found_position = i[FOUND_W-1:0];
                     break;
                  end
               end
            end
            FUNC_REMOVE: begin
               if (slot >= list_count) begin
                  r.status = STATUS_RANGE;
               end else begin
                  r.read_value = entries[slot];
                  for (i = slot; i + 1 < list_count; i++) entries[i] = entries[i+1];
                  list_count--;
               end
            end
            default: ;
         endcase
         r.count = list_count[COUNT_W-1:0];
         awaited.push_back(r);
      endfunction

      // Compare a result word with the oldest prediction, field by field.
      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t ns: result word with none expected (status %0d count %0d)",
                     $time, got.status, got.count);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status) begin
            $display("%0t ns: status expected %0d, got %0d", $time, want.status, got.status);
            mismatches++;
         end
         if (got.read_value !== want.read_value) begin
            $display("%0t ns: read_value expected %h, got %h",
                     $time, want.read_value, got.read_value);
            mismatches++;
         end
         if (got.found_position !== want.found_position) begin
            $display("%0t ns: found_position expected %0d, got %0d",
                     $time, want.found_position, got.found_position);
            mismatches++;
         end
         if (got.count !== want.count) begin
            $display("%0t ns: count expected %0d, got %0d", $time, want.count, got.count);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   iol_req_if req_ch ();
   iol_rsp_if rsp_ch ();

   indexed_ordered_list_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   list_scoreboard sb = new();

   int unsigned idle_cycles;
   int unsigned stall_phase_left;
   int unsigned stall_mode;
   int unsigned stall_tick;
   logic [31:0] value_pool [8];

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // Drive one request word and hold it until the block takes it.
   task automatic send_word(input logic [FUNC_W-1:0] f, input int unsigned p,
                            input logic [VALUE_W-1:0] v);
      req_type w;
      w.func       = f;
      w.position   = p[POS_W-1:0];
      w.item_value = v;
      req_ch.valid      <= 1'b1;
      req_ch.func       <= w.func;
      req_ch.position   <= w.position;
      req_ch.item_value <= w.item_value;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(w);
   endtask

   // Receiver: check accepted words, then pick the next ready from the stall pattern.
   always @(posedge clock) begin : receive
      rsp_type seen;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.status         = rsp_ch.status;
         seen.read_value     = rsp_ch.read_value;
         seen.found_position = rsp_ch.found_position;
         seen.count          = rsp_ch.count;
         sb.check_result(seen);
      end
      if (stall_phase_left == 0) begin
         stall_mode       = $urandom_range(0, 3);
         stall_phase_left = $urandom_range(20, 120);
      end else begin
         stall_phase_left--;
      end
      stall_tick++;
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= (stall_tick % 5 == 0);
      endcase
   end

   // Watchdog: give up after too long without any word moving.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned      done_words;
      int unsigned      burst_left;
      int unsigned      gap;
      int unsigned      fill_goal;
      int unsigned      goal_left;
      int unsigned      roll;
      int unsigned      cnt;
      int unsigned      p;
      int unsigned      i;
      bit               settled;
      logic [FUNC_W-1:0]  f;
      logic [VALUE_W-1:0] v;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_APPEND;
      req_ch.position   = '0;
      req_ch.item_value = '0;
      rsp_ch.ready      = 1'b0;
      idle_cycles       = 0;
      stall_phase_left  = 0;
      stall_mode        = 0;
      stall_tick        = 0;

      value_pool[0] = '0;
      value_pool[1] = ALL_ONES;
      value_pool[2] = 32'h0000_0001;
      value_pool[3] = 32'h8000_0000;
      for (i = 4; i < 8; i++) value_pool[i] = $urandom;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Empty list: every positional request is out of range, search misses.
      send_word(FUNC_GET, 15, '0);
      send_word(FUNC_INSERT, 0, 32'h1234_5678);
      send_word(FUNC_REMOVE, 0, '0);
      send_word(FUNC_INDEX_OF, 0, '0);
      send_word(FUNC_SPARE_HI, 15, ALL_ONES);

      // Fill to capacity with both extremes and a repeated value.
      for (i = 0; i < CAPACITY; i++) begin
         if (i == 0) v = '0;
         else if (i == CAPACITY - 1) v = ALL_ONES;
         else if (i == 3 || i == 9) v = TWIN_VALUE;
         else v = $urandom;
         send_word(FUNC_APPEND, 0, v);
      end

      // Full list: additions refused, search returns the first match, edges readable.
      send_word(FUNC_APPEND, 0, 32'h5A5A_5A5A);
      send_word(FUNC_INSERT, 15, 32'hA5A5_A5A5);
      send_word(FUNC_INDEX_OF, 0, TWIN_VALUE);
      send_word(FUNC_INDEX_OF, 0, ALL_ONES);
      send_word(FUNC_GET, 15, '0);
      send_word(FUNC_REMOVE, 15, '0);
      send_word(FUNC_INSERT, 0, 32'hC0FF_EE00);
      send_word(FUNC_REMOVE, 0, '0);

      // Random part: a drifting fill goal keeps the list sweeping empty to full.
      done_words = 0;
      burst_left = $urandom_range(1, 12);
      goal_left  = 0;
      fill_goal  = 0;
      settled    = 1'b0;
      while (done_words < WORD_TARGET) begin
         if (goal_left == 0) begin
            roll      = $urandom_range(0, 2);
            fill_goal = (roll == 0) ? 0 : (roll == 1) ? CAPACITY : $urandom_range(0, CAPACITY);
            goal_left = $urandom_range(30, 60);
         end
         goal_left--;
         cnt  = sb.list_count;
         roll = $urandom_range(0, 99);
         if (roll < 6)
            f = FUNC_W'(FUNC_SPARE_LO + $urandom_range(0, FUNC_SPARE_HI - FUNC_SPARE_LO));
         else if (roll < 24) f = FUNC_GET;
         else if (roll < 42) f = FUNC_INDEX_OF;
         else if ((cnt < fill_goal) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2))
            f = ($urandom_range(0, 1) != 0) ? FUNC_APPEND : FUNC_INSERT;
         else f = FUNC_REMOVE;
         if (cnt > 0 && $urandom_range(0, 9) < 8) p = $urandom_range(0, cnt - 1);
         else p = $urandom_range(0, 15);
         if ($urandom_range(0, 9) < 6) v = value_pool[$urandom_range(0, 7)];
         else v = $urandom;

         send_word(f, p, v);
         if (f <= FUNC_REMOVE) done_words++;

         // End a burst: a random gap, or once a full drain of results.
         if (burst_left > 0) burst_left--;
         if (burst_left == 0 || (!settled && done_words == SETTLE_POINT)) begin
            if (!settled && done_words == SETTLE_POINT) begin
               settled = 1'b1;
               req_ch.valid <= 1'b0;
               do @(posedge clock); while (sb.awaited.size() != 0);
            end else begin
               gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 15);
               if (gap != 0) begin
                  req_ch.valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
         end
      end

      // Drain outstanding results, then watch for strays.
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.awaited.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
